### rtl/core/alsdu_pkg.sv
// alsdu_pkg: shared types, codes and constants for the array list block
// used by the controller, the datapath, the top level and the port checker
`default_nettype none

package alsdu_pkg;

  localparam int DEPTH   = 64;
  localparam int AW      = $clog2(DEPTH);
  localparam int DATA_W  = 32;
  localparam int LEN_W   = 7;
  localparam int INIT_N  = 10;
  localparam int INIT_STEP = 100;
  localparam logic [LEN_W-1:0] INIT_LEN = LEN_W'((DEPTH < INIT_N) ? DEPTH : INIT_N);

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_BAD    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NONE  = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_CLEAR,
    S_BAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic grab;
    logic fin;
    logic shift;
    logic tail;
    logic bad;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic done;
    op_t  op;
  } sts_t;

  function automatic logic [DATA_W-1:0] init_value(input logic [AW-1:0] idx);
    logic [DATA_W-1:0] v;
    v = '0;
    if (int'(idx) < INIT_N) begin
      v = DATA_W'(INIT_STEP * (int'(idx) + 1));
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/alsdu_ctrl.sv
// alsdu_ctrl: sequencing state machine for search, delete and update
// depends on alsdu_pkg; drives the datapath through ctl_t
`default_nettype none

module alsdu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  alsdu_pkg::op_t     command,
  input  alsdu_pkg::sts_t    sts,
  output alsdu_pkg::ctl_t    ctl,
  output logic               busy
);
  import alsdu_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (command == OP_BAD) ? S_BAD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit && sts.op != OP_SEARCH) begin
          state_next = (sts.op == OP_DELETE) ? S_SHIFT : S_IDLE;
        end else if (sts.done) begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (sts.done) begin
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: state_next = S_IDLE;
      S_BAD:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      S_SCAN: begin
        if (sts.hit && sts.op != OP_SEARCH) begin
          ctl.grab = 1'b1;
        end else if (sts.done) begin
          ctl.fin = 1'b1;
        end else begin
          ctl.scan = 1'b1;
        end
      end
      S_SHIFT: ctl.shift = 1'b1;
      S_CLEAR: ctl.tail  = 1'b1;
      S_BAD:   ctl.bad   = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/alsdu_dp.sv
// alsdu_dp: list memory, scan pointer, compare and result registers
// depends on alsdu_pkg; commanded by alsdu_ctrl
`default_nettype none

module alsdu_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  alsdu_pkg::ctl_t                      ctl,
  input  alsdu_pkg::op_t                       command,
  input  wire logic signed [alsdu_pkg::DATA_W-1:0] key,
  input  wire logic signed [alsdu_pkg::DATA_W-1:0] new_value,
  output alsdu_pkg::sts_t                      sts,
  output logic                                 strobe,
  output logic [1:0]                           status,
  output logic [alsdu_pkg::LEN_W-1:0]          position,
  output logic [alsdu_pkg::LEN_W-1:0]          list_length,
  output logic                                 last
);
  import alsdu_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;

  op_t               op;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] nv_q;
  logic [LEN_W-1:0]  length;
  logic [LEN_W-1:0]  rd_ptr;
  logic              rvld;
  logic [AW-1:0]     ridx;
  logic [DATA_W-1:0] rmem_q;
  logic              rv_q;
  logic [DATA_W-1:0] rinit_q;
  logic [AW-1:0]     match;
  logic              pend;
  logic [LEN_W-1:0]  pend_pos;

  logic              more_rd;
  logic              rd_en;
  logic [DATA_W-1:0] rdata;
  logic              hit;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [LEN_W-1:0]  ridx_pos;
  logic [LEN_W-1:0]  len_dec;

  assign more_rd  = rd_ptr < length;
  assign rd_en    = (ctl.scan || ctl.shift) && more_rd;
  assign rdata    = rv_q ? rmem_q : rinit_q;
  assign hit      = rvld && (rdata == key_q);
  assign ridx_pos = LEN_W'(ridx) + LEN_W'(1);
  assign len_dec  = length - LEN_W'(1);

  assign sts.hit  = hit;
  assign sts.done = !more_rd && !rvld;
  assign sts.op   = op;

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = ridx;
    wdata = rdata;
    priority if (ctl.shift && rvld) begin
      we    = 1'b1;
      waddr = ridx - AW'(1);
      wdata = rdata;
    end else if (ctl.grab && op == OP_UPDATE) begin
      we    = 1'b1;
      waddr = ridx;
      wdata = nv_q;
    end else if (ctl.tail) begin
      we    = 1'b1;
      waddr = len_dec[AW-1:0];
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rmem_q  <= mem[rd_ptr[AW-1:0]];
      rv_q    <= valid[rd_ptr[AW-1:0]];
      rinit_q <= init_value(rd_ptr[AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // request latch and scan control
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op    <= command;
      key_q <= key;
      nv_q  <= new_value;
    end
    if (ctl.grab) begin
      match <= ridx;
    end
    if (ctl.scan && hit) begin
      pend_pos <= ridx_pos;
    end
    ridx <= rd_ptr[AW-1:0];
  end

  // load and grab never coincide with a read, so rvld drops by itself there
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= INIT_LEN;
      rd_ptr <= '0;
      rvld   <= 1'b0;
      pend   <= 1'b0;
    end else begin
      rvld <= rd_en;
      if (rd_en) begin
        rd_ptr <= rd_ptr + LEN_W'(1);
      end
      if (ctl.load) begin
        rd_ptr <= '0;
        pend   <= 1'b0;
      end
      if (ctl.scan && hit) begin
        pend <= 1'b1;
      end
      if (ctl.grab) begin
        rd_ptr <= ridx_pos;
        if (op == OP_UPDATE && nv_q == '0) begin
          length <= LEN_W'(ridx);
        end
      end
      if (ctl.tail) begin
        length <= len_dec;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (ctl.scan && hit && pend) || ctl.fin || ctl.bad || ctl.tail
                || (ctl.grab && op == OP_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctl.scan && hit) begin
      status      <= ST_FOUND;
      position    <= pend_pos;
      list_length <= length;
      last        <= 1'b0;
    end else if (ctl.fin) begin
      status      <= pend ? ST_FOUND : ST_NONE;
      position    <= pend ? pend_pos : '0;
      list_length <= length;
      last        <= 1'b1;
    end else if (ctl.grab) begin
      status      <= ST_FOUND;
      position    <= ridx_pos;
      list_length <= (nv_q == '0) ? LEN_W'(ridx) : length;
      last        <= 1'b1;
    end else if (ctl.tail) begin
      status      <= ST_FOUND;
      position    <= LEN_W'(match) + LEN_W'(1);
      list_length <= len_dec;
      last        <= 1'b1;
    end else if (ctl.bad) begin
      status      <= ST_BAD;
      position    <= '0;
      list_length <= length;
      last        <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/core/array_list_search_delete_update_top.sv
// array_list_search_delete_update_top: top level of the array list block
// depends on alsdu_pkg, alsdu_ctrl and alsdu_dp
`default_nettype none

// A request is taken when start is high and busy is low; results then come
// out one per strobe cycle and cannot be held off, so the receiver must take
// each one in the cycle it appears. The list sits in a memory with one read
// port and one write port that is walked one entry per clock: a search scans
// the whole list, a delete scans up to the match, then shifts the later
// entries down and clears the tail, an update stops at the match, a delete or
// update with no match scans the whole list, and an invalid command gives a
// single bad result. busy stays high until the last result of the request has
// been registered. No clearing pass runs after reset.
module array_list_search_delete_update_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          command,
  input  wire logic signed [alsdu_pkg::DATA_W-1:0] key,
  input  wire logic signed [alsdu_pkg::DATA_W-1:0] new_value,
  output logic                                     strobe,
  output logic [1:0]                               status,
  output logic [alsdu_pkg::LEN_W-1:0]              position,
  output logic [alsdu_pkg::LEN_W-1:0]              list_length,
  output logic                                     last
);
  import alsdu_pkg::*;

  ctl_t ctl;
  sts_t sts;
  op_t  cmd;

  assign cmd = op_t'(command);

  alsdu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (cmd),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy)
  );

  alsdu_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .command     (cmd),
    .key         (key),
    .new_value   (new_value),
    .sts         (sts),
    .strobe      (strobe),
    .status      (status),
    .position    (position),
    .list_length (list_length),
    .last        (last)
  );

endmodule

`default_nettype wire

### rtl/core/alsdu_chk.sv
// alsdu_chk: port-level checks for the array list block
// depends on alsdu_pkg; bound to array_list_search_delete_update_top
`default_nettype none

module alsdu_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        strobe,
  input wire logic [1:0]                  status,
  input wire logic [alsdu_pkg::LEN_W-1:0] position,
  input wire logic                        last
);
  import alsdu_pkg::*;

  // a taken request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low right after accepted request");

  // not found and invalid end the request at once
  a_miss_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status != ST_FOUND |-> last && position == '0)
    else $error("miss result not final or has position");

  // a found result points into the list
  a_found_pos: assert property (@(posedge clk) disable iff (rst)
    strobe && status == ST_FOUND |-> position != '0 && position <= LEN_W'(DEPTH))
    else $error("found result with bad position");

  // nothing follows the final result without a new request
  a_last_quiet: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result after final result");

  // non-final results only come while a request is open
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final result while idle");

endmodule

bind array_list_search_delete_update_top alsdu_chk u_alsdu_chk (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .strobe   (strobe),
  .status   (status),
  .position (position),
  .last     (last)
);

`default_nettype wire

### dv/tb_top.sv
// tb_top: self-checking testbench for array_list_search_delete_update_top
// holds a predictor of the list, a queued request driver and a result monitor
// depends on alsdu_pkg and the rtl of the array list block
module tb_top;
  import alsdu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 80;
  localparam int N_RANDOM    = 310;

  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic [31:0] new_value;
    logic        drain_first;
  } list_cmd_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] position;
    logic [LEN_W-1:0] list_length;
    logic             last;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               command = OP_SEARCH;
  logic signed [DATA_W-1:0] key = '0;
  logic signed [DATA_W-1:0] new_value = '0;
  logic                     busy;
  logic                     strobe;
  logic [1:0]               status;
  logic [LEN_W-1:0]         position;
  logic [LEN_W-1:0]         list_length;
  logic                     last;

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];
  list_cmd_t    cur_cmd;
  list_result_t got_exp;

  logic [DATA_W-1:0] list_mem [0:DEPTH-1];
  int                list_len;

  int errors = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_found = 0;
  int n_none = 0;
  int n_bad = 0;
  int cycles = 0;

  array_list_search_delete_update_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .key(key),
    .new_value(new_value),
    .strobe(strobe),
    .status(status),
    .position(position),
    .list_length(list_length),
    .last(last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic push_result(input status_t s, input int pos, input logic lst);
    list_result_t r;
    r.status = s;
    r.position = LEN_W'(pos);
    r.list_length = LEN_W'(list_len);
    r.last = lst;
    expected_results.push_back(r);
  endtask

  // applies one request to the list copy and queues the results it causes
  task automatic run_list_cmd(input list_cmd_t c);
    int hits;
    int seen;
    int hit_pos;
    hits = 0;
    seen = 0;
    hit_pos = -1;
    case (c.op)
      OP_SEARCH: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == c.key) hits++;
        end
        if (hits == 0) begin
          push_result(ST_NONE, 0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            if (list_mem[i] == c.key) begin
              seen++;
              push_result(ST_FOUND, i + 1, seen == hits);
            end
          end
        end
      end
      OP_DELETE, OP_UPDATE: begin
        for (int i = 0; i < list_len; i++) begin
          if (hit_pos < 0 && list_mem[i] == c.key) hit_pos = i;
        end
        if (hit_pos < 0) begin
          push_result(ST_NONE, 0, 1'b1);
        end else if (c.op == OP_DELETE) begin
          for (int j = hit_pos; j + 1 < list_len; j++) list_mem[j] = list_mem[j + 1];
          list_mem[list_len - 1] = '0;
          list_len--;
          push_result(ST_FOUND, hit_pos + 1, 1'b1);
        end else begin
          list_mem[hit_pos] = c.new_value;
          if (c.new_value == 0) list_len = hit_pos;
          push_result(ST_FOUND, hit_pos + 1, 1'b1);
        end
      end
      default: begin
        push_result(ST_BAD, 0, 1'b1);
      end
    endcase
  endtask

  task automatic add_cmd(input op_t op, input logic [31:0] k, input logic [31:0] nv,
                         input logic drain);
    list_cmd_t c;
    c.op = op;
    c.key = k;
    c.new_value = nv;
    c.drain_first = drain;
    pending_cmds.push_back(c);
  endtask

  // mostly values that can sit in the list, sometimes any 32-bit pattern
  function automatic logic [31:0] pick_value(input logic allow_zero);
    logic [31:0] v;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) v = 32'(100 * $urandom_range(1, 10));
    else if (r < 70) begin
      case ($urandom_range(0, 3))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'hffff_ffff;
        default: v = 32'd1;
      endcase
    end else if (r < 75 && allow_zero) v = '0;
    else v = $urandom;
    if (!allow_zero && v == 0) v = 32'd7;
    return v;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        run_list_cmd(cur_cmd);
        n_accepted++;
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() == 0) begin
          start <= 1'b0;
        end else if (pending_cmds[0].drain_first && (expected_results.size() != 0 || busy)) begin
          start <= 1'b0;
        end else if ((n_accepted < 120 || n_accepted > 200) && $urandom_range(0, 99) < 6) begin
          start <= 1'b0;
        end else begin
          cur_cmd = pending_cmds.pop_front();
          start <= 1'b1;
          command <= cur_cmd.op;
          key <= cur_cmd.key;
          new_value <= cur_cmd.new_value;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status %0d position %0d length %0d last %0d",
                 $time, status, position, list_length, last);
      end else begin
        got_exp = expected_results.pop_front();
        n_checked++;
        case (got_exp.status)
          ST_FOUND: n_found++;
          ST_NONE:  n_none++;
          default:  n_bad++;
        endcase
        check_field("status", got_exp.status, status);
        check_field("position", got_exp.position, position);
        check_field("list_length", got_exp.list_length, list_length);
        check_field("last", got_exp.last, last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("array_list_search_delete_update_top: mismatch");
      $finish;
    end
  end

  initial begin
    int r;
    op_t op;
    for (int i = 0; i < DEPTH; i++) begin
      list_mem[i] = (i < INIT_N) ? DATA_W'(INIT_STEP * (i + 1)) : '0;
    end
    list_len = int'(INIT_LEN);

    // directed part
    add_cmd(OP_SEARCH, 32'd100, 32'd0, 1'b0);
    add_cmd(OP_SEARCH, 32'd1000, 32'd0, 1'b0);
    add_cmd(OP_SEARCH, 32'd0, 32'd0, 1'b0);
    add_cmd(OP_SEARCH, 32'h7fff_ffff, 32'd0, 1'b0);
    add_cmd(OP_SEARCH, 32'h8000_0000, 32'hffff_ffff, 1'b0);
    add_cmd(OP_BAD, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_cmd(OP_BAD, 32'd0, 32'd0, 1'b0);
    add_cmd(OP_UPDATE, 32'd500, 32'd300, 1'b0);
    add_cmd(OP_SEARCH, 32'd300, 32'd0, 1'b0);
    add_cmd(OP_UPDATE, 32'd0, 32'd5, 1'b0);
    add_cmd(OP_DELETE, 32'd0, 32'd0, 1'b0);
    add_cmd(OP_DELETE, 32'd100, 32'd0, 1'b0);
    add_cmd(OP_DELETE, 32'd1000, 32'd0, 1'b0);
    add_cmd(OP_DELETE, 32'd12345, 32'd0, 1'b0);
    add_cmd(OP_UPDATE, 32'd200, 32'h7fff_ffff, 1'b0);
    add_cmd(OP_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    add_cmd(OP_SEARCH, 32'h8000_0000, 32'd0, 1'b0);
    add_cmd(OP_UPDATE, 32'd900, 32'd0, 1'b0);
    add_cmd(OP_SEARCH, 32'd900, 32'd0, 1'b0);
    add_cmd(OP_SEARCH, 32'd300, 32'd0, 1'b0);
    add_cmd(OP_UPDATE, 32'd12345, 32'd0, 1'b0);

    // random part: keep the list long at first, shrink it near the end
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (i < 250) begin
        op = (r < 45) ? OP_SEARCH : (r < 88) ? OP_UPDATE : (r < 94) ? OP_DELETE : OP_BAD;
      end else begin
        op = (r < 40) ? OP_SEARCH : (r < 50) ? OP_UPDATE : (r < 85) ? OP_DELETE : OP_BAD;
      end
      add_cmd(op, pick_value(1'b1), pick_value(i >= 250 && $urandom_range(0, 2) == 0),
              i == 0 || i == 150);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0 || busy) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("requests accepted %0d, results checked %0d (found %0d, not found %0d, bad %0d)",
             n_accepted, n_checked, n_found, n_none, n_bad);
    $display("final list length %0d, %0d errors", list_len, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("array_list_search_delete_update_top: match");
    end else begin
      $display("array_list_search_delete_update_top: mismatch");
    end
    $finish;
  end

endmodule

### array_list_search_delete_update_top.f
rtl/core/alsdu_pkg.sv
rtl/core/alsdu_ctrl.sv
rtl/core/alsdu_dp.sv
rtl/core/array_list_search_delete_update_top.sv
rtl/core/alsdu_chk.sv
dv/tb_top.sv
